/* hw/rtl/c3v_pkg.sv */
// Shared constants, types and register codes for the 3x3 RGB convolution block.
package c3v_pkg;

  // Default geometry and sample width handed to the top-level parameters.
  localparam int DEF_MAX_WIDTH   = 2048;
  localparam int DEF_MAX_HEIGHT  = 4096;
  localparam int DEF_SAMPLE_BITS = 16;

  // Kernel format: signed Q2.14 taps, three to a row word.
  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 14;
  localparam int KERN_DIM  = 3;
  localparam int WIN_TAPS  = KERN_DIM * KERN_DIM;
  localparam int NUM_CH    = 3;

  // Configuration port.
  localparam int CFG_DW     = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int IMG_W_BITS = 12;
  localparam int IMG_H_BITS = 13;
  localparam int IMG_W_RST  = 2048;
  localparam int IMG_H_RST  = 1024;
  localparam int MIN_DIM    = 3;

  // Pipeline depth of one channel lane and size of the result queue.
  localparam int LANE_LAT  = 4;
  localparam int OUT_DEPTH = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_TOP = 3'd0,
    REG_COEF_MID = 3'd1,
    REG_COEF_BOT = 3'd2,
    REG_IMG_W    = 3'd3,
    REG_IMG_H    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } flag_t;

endpackage

/* hw/rtl/conv2d_3x3_valid_rgb.sv */
// Top level of the streaming 3x3 valid-mode RGB convolution.
//
// Streaming 3x3 convolution of RGB pixels in raster order, valid mode: an image of
// W x H input pixels gives (W-2) x (H-2) results, one for every position where the
// whole 3x3 window fits, with the top-left kernel tap on the top-left pixel. The same
// signed Q2.14 kernel is applied to all three channels by three identical lanes that
// run side by side; each sum is rounded half up, shifted right by 14 and clipped to
// 0..2^SAMPLE_BITS-1. One pixel is taken every clock while in_stall is low: the only
// loop is the column step, which moves one memory word per pixel through a single
// read and a single write port of the line store. A result passes the line store
// read, window, four lane stages and the 8-entry result queue. Outside the line
// store sweep, in_stall rises only when every queue slot is spoken for by a request
// already taken, so the input keeps moving while out_stall holds a result. After
// reset the line store is swept clean, one column a cycle; in_stall stays high
// meanwhile, and configuration writes are taken as usual.
// Image width and height are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT. Change
// geometry or kernel only between requests; a new width or height takes effect on
// the next pixel. out_row_end marks the last result of an output row and
// out_frame_end the last result of the frame.
module conv2d_3x3_valid_rgb #(
  parameter int MAX_WIDTH   = c3v_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = c3v_pkg::DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = c3v_pkg::DEF_SAMPLE_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // pixel requests
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [SAMPLE_BITS-1:0]           in_red,
  input  logic [SAMPLE_BITS-1:0]           in_green,
  input  logic [SAMPLE_BITS-1:0]           in_blue,
  // filtered results
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [SAMPLE_BITS-1:0]           out_red,
  output logic [SAMPLE_BITS-1:0]           out_green,
  output logic [SAMPLE_BITS-1:0]           out_blue,
  output logic                             out_row_end,
  output logic                             out_frame_end,
  // configuration
  input  logic                             cfg_we,
  input  logic [c3v_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [c3v_pkg::CFG_DW-1:0]       cfg_wdata
);
  import c3v_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WE_W   = $clog2(MAX_WIDTH + 1);
  localparam int HE_W   = $clog2(MAX_HEIGHT + 1);
  localparam int WCW    = (IMG_W_BITS > WE_W) ? IMG_W_BITS : WE_W;
  localparam int HCW    = (IMG_H_BITS > HE_W) ? IMG_H_BITS : HE_W;
  localparam int PIX_W  = NUM_CH * SAMPLE_BITS;
  localparam int PEND_W = $clog2(OUT_DEPTH + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_DW-1:0]     coef_top_r, coef_mid_r, coef_bot_r;
  logic [IMG_W_BITS-1:0] img_w_r;
  logic [IMG_H_BITS-1:0] img_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_top_r <= '0;
      coef_mid_r <= '0;
      coef_bot_r <= '0;
      img_w_r    <= IMG_W_BITS'(IMG_W_RST);
      img_h_r    <= IMG_H_BITS'(IMG_H_RST);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_COEF_TOP: coef_top_r <= cfg_wdata;
        REG_COEF_MID: coef_mid_r <= cfg_wdata;
        REG_COEF_BOT: coef_bot_r <= cfg_wdata;
        REG_IMG_W:    img_w_r    <= cfg_wdata[IMG_W_BITS-1:0];
        REG_IMG_H:    img_h_r    <= cfg_wdata[IMG_H_BITS-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Effective geometry, clamped to what the line store can hold.
  logic [WE_W-1:0] w_eff;
  logic [HE_W-1:0] h_eff;

  always_comb begin
    if (img_w_r < IMG_W_BITS'(MIN_DIM)) begin
      w_eff = WE_W'(MIN_DIM);
    end else if (WCW'(img_w_r) > WCW'(MAX_WIDTH)) begin
      w_eff = WE_W'(MAX_WIDTH);
    end else begin
      w_eff = WE_W'(img_w_r);
    end
    if (img_h_r < IMG_H_BITS'(MIN_DIM)) begin
      h_eff = HE_W'(MIN_DIM);
    end else if (HCW'(img_h_r) > HCW'(MAX_HEIGHT)) begin
      h_eff = HE_W'(MAX_HEIGHT);
    end else begin
      h_eff = HE_W'(img_h_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: accept, position counters, line store read
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              last_col, last_row, produce;
  logic              in_acc;
  logic              clr_busy;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              out_acc;

  assign last_col = (WE_W'(col_r) + WE_W'(1)) >= w_eff;
  assign last_row = (HE_W'(row_r) + HE_W'(1)) >= h_eff;
  assign produce  = (col_r >= COL_W'(2)) && (row_r >= ROW_W'(2));

  // Hold off new requests while the store is swept or every queue slot is claimed.
  assign in_stall = clr_busy || (pend_r >= PEND_W'(OUT_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // Count results owed: taken requests that make a result, not yet delivered.
  always_comb begin
    pend_nxt = pend_r;
    unique case ({in_acc && produce, out_acc})
      2'b10:   pend_nxt = pend_r + PEND_W'(1);
      2'b01:   pend_nxt = pend_r - PEND_W'(1);
      default: pend_nxt = pend_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line store data back, write the column, shift the window
  // ---------------------------------------------------------------------------
  // Line store word: low half is the oldest row, high half the previous row.
  logic                 s1_vld_r, s1_prod_r;
  flag_t                s1_flags_r;
  logic [COL_W-1:0]     s1_col_r;
  logic [PIX_W-1:0]     s1_pix_r;
  logic [2*PIX_W-1:0]   lb_rd_data;
  logic [PIX_W-1:0]     col_pix [KERN_DIM];
  logic [PIX_W-1:0]     win_old_r [KERN_DIM];
  logic [PIX_W-1:0]     win_mid_r [KERN_DIM];

  // Consecutive pixels never share a column (width is at least three), so the
  // stage 1 write never collides with the stage 0 read.
  c3v_line_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .WORD_W    (2 * PIX_W)
  ) u_line_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (col_r),
    .rd_data  (lb_rd_data),
    .wr_en    (s1_vld_r),
    .wr_addr  (s1_col_r),
    .wr_data  ({s1_pix_r, lb_rd_data[PIX_W +: PIX_W]}),
    .clr_busy (clr_busy)
  );

  assign col_pix[0] = lb_rd_data[0 +: PIX_W];
  assign col_pix[1] = lb_rd_data[PIX_W +: PIX_W];
  assign col_pix[2] = s1_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_prod_r  <= produce;
      s1_flags_r <= '{row_end: last_col, frame_end: last_col && last_row};
      s1_col_r   <= col_r;
      s1_pix_r   <= {in_blue, in_green, in_red};
    end
    // Advance the window one column per pixel.
    if (s1_vld_r) begin
      for (int k = 0; k < KERN_DIM; k++) begin
        win_old_r[k] <= win_mid_r[k];
        win_mid_r[k] <= col_pix[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: register the full 3x3 window for the lanes
  // ---------------------------------------------------------------------------
  logic                              s2_vld_r;
  flag_t                             s2_flags_r;
  logic [WIN_TAPS-1:0][PIX_W-1:0]    s2_win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r && s1_prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && s1_prod_r) begin
      s2_flags_r <= s1_flags_r;
      for (int k = 0; k < KERN_DIM; k++) begin
        s2_win_r[3*k]   <= win_old_r[k];
        s2_win_r[3*k+1] <= win_mid_r[k];
        s2_win_r[3*k+2] <= col_pix[k];
      end
    end
  end

  // Kernel taps laid out like the window: row-major, left tap first.
  logic [CFG_DW-1:0]                     krow [KERN_DIM];
  logic [WIN_TAPS-1:0][COEF_W-1:0]       coef_all;

  assign krow[0] = coef_top_r;
  assign krow[1] = coef_mid_r;
  assign krow[2] = coef_bot_r;

  always_comb begin
    for (int k = 0; k < KERN_DIM; k++) begin
      for (int j = 0; j < KERN_DIM; j++) begin
        coef_all[3*k+j] = krow[k][COEF_W*j +: COEF_W];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Channel lanes (red, green, blue) run in lockstep
  // ---------------------------------------------------------------------------
  logic [NUM_CH-1:0]                     lane_vld;
  logic [NUM_CH-1:0][SAMPLE_BITS-1:0]    lane_res;

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    logic [WIN_TAPS-1:0][SAMPLE_BITS-1:0] smp;

    always_comb begin
      for (int i = 0; i < WIN_TAPS; i++) begin
        smp[i] = s2_win_r[i][ch*SAMPLE_BITS +: SAMPLE_BITS];
      end
    end

    c3v_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (s2_vld_r),
      .smp_i  (smp),
      .coef_i (coef_all),
      .vld_o  (lane_vld[ch]),
      .res_o  (lane_res[ch])
    );
  end

  // Flags ride alongside the lanes.
  flag_t flag_pipe_r [LANE_LAT];

  always_ff @(posedge clk) begin
    flag_pipe_r[0] <= s2_flags_r;
    for (int i = 1; i < LANE_LAT; i++) begin
      flag_pipe_r[i] <= flag_pipe_r[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Merge and result queue
  // ---------------------------------------------------------------------------
  logic [NUM_CH-1:0][SAMPLE_BITS-1:0] q_res;
  flag_t                              q_flags;

  c3v_out_fifo #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_out_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (lane_vld[0]),
    .res_i       (lane_res),
    .flags_i     (flag_pipe_r[LANE_LAT-1]),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .res_o       (q_res),
    .flags_o     (q_flags)
  );

  assign out_red       = q_res[0];
  assign out_green     = q_res[1];
  assign out_blue      = q_res[2];
  assign out_row_end   = q_flags.row_end;
  assign out_frame_end = q_flags.frame_end;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(OUT_DEPTH))
    else $error("owed result count exceeds queue depth");

  a_out_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != '0))
    else $error("result offered with no request owed");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_vld[0] == lane_vld[1]) && (lane_vld[1] == lane_vld[2]))
    else $error("channel lanes out of step");

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |=> !s1_vld_r)
    else $error("pixel taken during line store sweep");

endmodule

/* hw/rtl/c3v_line_buf.sv */
// Two-row line store held in one memory word per column, with a clearing pass after reset.
module c3v_line_buf #(
  parameter int MAX_WIDTH = c3v_pkg::DEF_MAX_WIDTH,
  parameter int WORD_W    = 6 * c3v_pkg::DEF_SAMPLE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic [WORD_W-1:0]            rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [WORD_W-1:0]            wr_data,
  output logic                         clr_busy
);
  import c3v_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic [WORD_W-1:0] mem [MAX_WIDTH];
  logic [WORD_W-1:0] rd_data_r;
  logic [AW-1:0]     clr_cnt_r;
  logic [AW-1:0]     clr_cnt_nxt;
  logic              clr_busy_r;
  logic              clr_busy_nxt;

  // Sweep every column once after reset, one per cycle.
  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      if (clr_cnt_r == AW'(MAX_WIDTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

/* hw/rtl/c3v_lane.sv */
// One channel lane: nine products, row sums, total with rounding, shift and saturate.
module c3v_lane #(
  parameter int SAMPLE_BITS = c3v_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               vld_i,
  input  logic [c3v_pkg::WIN_TAPS-1:0][SAMPLE_BITS-1:0]      smp_i,
  input  logic [c3v_pkg::WIN_TAPS-1:0][c3v_pkg::COEF_W-1:0]  coef_i,
  output logic                                               vld_o,
  output logic [SAMPLE_BITS-1:0]                             res_o
);
  import c3v_pkg::*;

  localparam int PW = SAMPLE_BITS + 1 + COEF_W;  // one product
  localparam int RW = PW + 2;                    // sum of three products
  localparam int SW = PW + 4;                    // sum of nine, plus rounding
  localparam int QW = SW - 1 - FRAC_BITS;        // non-negative quotient
  localparam logic signed [SW-1:0] RND = SW'(1) << (FRAC_BITS - 1);

  logic signed [PW-1:0]    prod_r [WIN_TAPS];
  logic signed [RW-1:0]    row_r  [KERN_DIM];
  logic signed [SW-1:0]    sum_r;
  logic [SAMPLE_BITS-1:0]  res_r;
  logic [SAMPLE_BITS-1:0]  res_nxt;
  logic [QW-1:0]           quo;
  logic [LANE_LAT-1:0]     vld_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_TAPS; i++) begin
      prod_r[i] <= $signed({1'b0, smp_i[i]}) * $signed(coef_i[i]);
    end
    for (int k = 0; k < KERN_DIM; k++) begin
      row_r[k] <= RW'(prod_r[3*k]) + RW'(prod_r[3*k+1]) + RW'(prod_r[3*k+2]);
    end
    sum_r <= SW'(row_r[0]) + SW'(row_r[1]) + SW'(row_r[2]) + RND;
    res_r <= res_nxt;
  end

  // Drop negatives to zero, clip anything past full scale.
  always_comb begin
    quo = sum_r[SW-2:FRAC_BITS];
    if (sum_r[SW-1]) begin
      res_nxt = '0;
    end else if (|quo[QW-1:SAMPLE_BITS]) begin
      res_nxt = '1;
    end else begin
      res_nxt = quo[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LANE_LAT-2:0], vld_i};
    end
  end

  assign vld_o = vld_r[LANE_LAT-1];
  assign res_o = res_r;

endmodule

/* hw/rtl/c3v_out_fifo.sv */
// Merge stage: joins the three lane results with the position flags in a small result queue.
module c3v_out_fifo #(
  parameter int SAMPLE_BITS = c3v_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          push_i,
  input  logic [c3v_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0]   res_i,
  input  c3v_pkg::flag_t                                flags_i,
  output logic                                          out_valid_o,
  input  logic                                          out_stall_i,
  output logic [c3v_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0]   res_o,
  output c3v_pkg::flag_t                                flags_o
);
  import c3v_pkg::*;

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  logic [NUM_CH-1:0][SAMPLE_BITS-1:0] res_q [OUT_DEPTH];
  flag_t                              flg_q [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid_o = (cnt_r != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign res_o       = res_q[rd_ptr_r];
  assign flags_o     = flg_q[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    unique case ({push_i, pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      res_q[wr_ptr_r] <= res_i;
      flg_q[wr_ptr_r] <= flags_i;
    end
  end

endmodule
